FILE: src/lmms_pkg.sv
package lmms_pkg;

    localparam int NUM_COLS = 16;
    localparam int MSG_COLS = 11;
    localparam int QUEUE_DEPTH = 2;

    localparam int EMG_PERIOD = 32;
    localparam int ALARM_PERIOD = 39;
    localparam int PARK_PERIOD = 63;
    localparam int EMG_LEN = 21;
    localparam int ALARM_LEN = 28;
    localparam int PARK_LEN = 52;
    localparam int ARROW_PERIOD = 11;
    localparam int ARROW_SHIFT_STEPS = 8;
    localparam int ROLL_PERIOD = 9;

    localparam int FLAG_EMG = 0;
    localparam int FLAG_AUTO = 1;
    localparam int FLAG_FIRE = 2;
    localparam int FLAG_STOP = 3;
    localparam int FLAG_FULL = 4;
    localparam int FLAG_OVL = 5;
    localparam int FLAG_PARK = 6;
    localparam int FLAG_UP = 7;
    localparam int FLAG_DOWN = 8;
    localparam int FLAG_SHIFT = 9;

    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_STATUS = 2'd1,
        REQ_TICK = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_STATUS,
        CMD_TICK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [3:0]  index;
        logic [7:0]  data;
        logic [7:0]  floor;
        logic [9:0]  flags;
    } cmd_t;

    typedef enum logic [3:0] {
        MSG_EMG,
        MSG_INS,
        MSG_FIRE,
        MSG_STOP,
        MSG_FULL,
        MSG_PARK,
        MSG_OVL,
        MSG_COPY,
        MSG_ROLL,
        MSG_HOLD
    } msg_mode_t;

    typedef enum logic [1:0] {
        ARW_COPY,
        ARW_SHIFT,
        ARW_HOLD
    } arrow_mode_t;

    localparam logic [7:0] ROM_EMG [EMG_LEN] = '{
        8'h00, 8'h00, 8'h7F, 8'h49, 8'h49, 8'h49, 8'h41, 8'h00,
        8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F, 8'h00, 8'h3E, 8'h41,
        8'h49, 8'h49, 8'h7A, 8'h00, 8'h00};
    localparam logic [7:0] ROM_INS [EMG_LEN] = '{
        8'h00, 8'h00, 8'h00, 8'h41, 8'h7F, 8'h41, 8'h00, 8'h00,
        8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F, 8'h00, 8'h46, 8'h49,
        8'h49, 8'h49, 8'h31, 8'h00, 8'h00};
    localparam logic [7:0] ROM_FIRE [ALARM_LEN] = '{
        8'h00, 8'h00, 8'h7F, 8'h09, 8'h09, 8'h09, 8'h01, 8'h00,
        8'h00, 8'h41, 8'h7F, 8'h41, 8'h00, 8'h00, 8'h7F, 8'h09,
        8'h19, 8'h29, 8'h46, 8'h00, 8'h7F, 8'h49, 8'h49, 8'h49,
        8'h41, 8'h00, 8'h00, 8'h00};
    localparam logic [7:0] ROM_STOP [ALARM_LEN] = '{
        8'h00, 8'h00, 8'h46, 8'h49, 8'h49, 8'h49, 8'h31, 8'h00,
        8'h01, 8'h01, 8'h7F, 8'h01, 8'h01, 8'h00, 8'h3E, 8'h41,
        8'h41, 8'h41, 8'h3E, 8'h00, 8'h7F, 8'h09, 8'h09, 8'h09,
        8'h06, 8'h00, 8'h00, 8'h00};
    localparam logic [7:0] ROM_FULL [ALARM_LEN] = '{
        8'h00, 8'h00, 8'h7F, 8'h09, 8'h09, 8'h09, 8'h01, 8'h00,
        8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F, 8'h00, 8'h7F, 8'h40,
        8'h40, 8'h40, 8'h40, 8'h00, 8'h7F, 8'h40, 8'h40, 8'h40,
        8'h40, 8'h00, 8'h00, 8'h00};
    localparam logic [7:0] ROM_OVL [PARK_LEN] = '{
        8'h00, 8'h00, 8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E, 8'h00,
        8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F, 8'h00, 8'h7F, 8'h49,
        8'h49, 8'h49, 8'h41, 8'h00, 8'h7F, 8'h09, 8'h19, 8'h29,
        8'h46, 8'h00, 8'h7F, 8'h40, 8'h40, 8'h40, 8'h40, 8'h00,
        8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E, 8'h00, 8'h7E, 8'h11,
        8'h11, 8'h11, 8'h7E, 8'h00, 8'h7F, 8'h41, 8'h41, 8'h22,
        8'h1C, 8'h00, 8'h00, 8'h00};
    localparam logic [7:0] ROM_PARK [PARK_LEN] = '{
        8'h00, 8'h00, 8'h7F, 8'h09, 8'h09, 8'h09, 8'h06, 8'h00,
        8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E, 8'h00, 8'h7F, 8'h09,
        8'h19, 8'h29, 8'h46, 8'h00, 8'h7F, 8'h08, 8'h14, 8'h22,
        8'h41, 8'h00, 8'h00, 8'h41, 8'h7F, 8'h41, 8'h00, 8'h00,
        8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F, 8'h00, 8'h3E, 8'h41,
        8'h49, 8'h49, 8'h7A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00};

    function automatic logic is_marquee(msg_mode_t mode);
        return (mode != MSG_COPY) && (mode != MSG_ROLL) && (mode != MSG_HOLD);
    endfunction

    function automatic logic [5:0] rom_len(msg_mode_t mode);
        logic [5:0] len;
        case (mode)
            MSG_EMG, MSG_INS: len = 6'(EMG_LEN);
            MSG_FIRE, MSG_STOP, MSG_FULL: len = 6'(ALARM_LEN);
            default: len = 6'(PARK_LEN);
        endcase
        return len;
    endfunction

    function automatic logic [6:0] rom_period(msg_mode_t mode);
        logic [6:0] period;
        case (mode)
            MSG_EMG, MSG_INS: period = 7'(EMG_PERIOD);
            MSG_FIRE, MSG_STOP, MSG_FULL: period = 7'(ALARM_PERIOD);
            default: period = 7'(PARK_PERIOD);
        endcase
        return period;
    endfunction

    function automatic logic [7:0] rom_byte(msg_mode_t mode, logic [5:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (mode)
            MSG_EMG: if (idx < 6'(EMG_LEN)) b = ROM_EMG[idx[4:0]];
            MSG_INS: if (idx < 6'(EMG_LEN)) b = ROM_INS[idx[4:0]];
            MSG_FIRE: if (idx < 6'(ALARM_LEN)) b = ROM_FIRE[idx[4:0]];
            MSG_STOP: if (idx < 6'(ALARM_LEN)) b = ROM_STOP[idx[4:0]];
            MSG_FULL: if (idx < 6'(ALARM_LEN)) b = ROM_FULL[idx[4:0]];
            MSG_PARK: if (idx < 6'(PARK_LEN)) b = ROM_PARK[idx];
            MSG_OVL: if (idx < 6'(PARK_LEN)) b = ROM_OVL[idx];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: src/lmms_front.sv
module lmms_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     req_type,
    input  logic [3:0]     column_index,
    input  logic [7:0]     column_data,
    input  logic [7:0]     floor_number,
    input  logic [9:0]     status_flags,
    output logic           cmd_valid,
    input  logic           cmd_ready,
    output lmms_pkg::cmd_t cmd
);
    import lmms_pkg::*;

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    cmd_t              in_cmd;
    logic              legal;
    logic              push;
    logic              pop;

    always_comb
    begin
        in_cmd.index = column_index;
        in_cmd.data = column_data;
        in_cmd.floor = floor_number;
        in_cmd.flags = status_flags;
        legal = 1'b1;
        unique case (req_type)
            REQ_LOAD: in_cmd.kind = CMD_LOAD;
            REQ_STATUS: in_cmd.kind = CMD_STATUS;
            REQ_TICK: in_cmd.kind = CMD_TICK;
            default:
            begin
                in_cmd.kind = CMD_LOAD;
                legal = 1'b0;
            end
        endcase
    end

    assign in_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign cmd_valid = count_reg != '0;
    assign cmd = queue_reg[rd_ptr_reg];
    assign push = in_valid && in_ready && legal;
    assign pop = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("command queue holds more entries than its depth");

    a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue fill did not grow on a push");

endmodule

FILE: src/lmms_back.sv
module lmms_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  lmms_pkg::cmd_t cmd,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [3:0]     out_column,
    output logic [7:0]     out_dots,
    output logic           last_column
);
    import lmms_pkg::*;

    typedef enum logic {ST_IDLE, ST_EMIT} state_t;

    state_t      state_reg, state_next;
    logic [3:0]  col_reg, col_next;
    logic [5:0]  j_reg, j_next;
    logic [5:0]  sp_reg, sp_next;
    logic [3:0]  phase_reg, phase_next;
    logic        roll_reg, roll_next;
    logic        active_reg, active_next;
    logic [7:0]  prev_floor_reg, prev_floor_next;
    logic [9:0]  flags_reg, flags_next;
    msg_mode_t   msg_mode_reg, msg_mode_next;
    arrow_mode_t arrow_mode_reg, arrow_mode_next;
    logic [7:0]  glyph_reg [NUM_COLS];
    logic [7:0]  glyph_next [NUM_COLS];
    logic [7:0]  shown_reg [NUM_COLS];
    logic [7:0]  shown_next [NUM_COLS];
    logic        out_valid_reg, out_valid_next;
    logic [3:0]  out_col_reg, out_col_next;
    logic [7:0]  out_dots_reg, out_dots_next;
    logic        out_last_reg, out_last_next;

    logic        take;
    logic        advance;
    logic        up;
    logic        motion;
    logic [6:0]  sp_inc;
    msg_mode_t   msg_sel;
    logic [5:0]  sp_new;
    logic [3:0]  phase_new;
    logic        in_msg;
    logic        marquee_col;
    logic [5:0]  len;
    logic [6:0]  period;
    logic        j_in_rom;
    logic [6:0]  j_inc;
    logic [5:0]  j_step;
    logic [3:0]  glyph_idx;
    logic [7:0]  g;
    logic [7:0]  s;
    logic [3:0]  amt;
    logic [2:0]  k;
    logic [7:0]  msg_dots;
    logic [7:0]  arrow_dots;
    logic [7:0]  col_dots;

    function automatic logic [6:0] wrap_mod(logic [6:0] v, logic [6:0] p);
        return (v >= p) ? v - p : v;
    endfunction

    assign cmd_ready = state_reg == ST_IDLE;
    assign take = cmd_valid && cmd_ready;
    assign advance = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    assign up = flags_reg[FLAG_UP];
    assign motion = flags_reg[FLAG_SHIFT] && (flags_reg[FLAG_UP] || flags_reg[FLAG_DOWN]);
    assign sp_inc = {1'b0, sp_reg} + 7'd1;

    always_comb
    begin
        if (flags_reg[FLAG_EMG] || !flags_reg[FLAG_AUTO])
        begin
            msg_sel = flags_reg[FLAG_EMG] ? MSG_EMG : MSG_INS;
        end
        else if (flags_reg[FLAG_FIRE] || flags_reg[FLAG_STOP] || flags_reg[FLAG_FULL])
        begin
            msg_sel = flags_reg[FLAG_FIRE] ? MSG_FIRE :
                      flags_reg[FLAG_STOP] ? MSG_STOP : MSG_FULL;
        end
        else if (flags_reg[FLAG_OVL] || flags_reg[FLAG_PARK])
        begin
            msg_sel = flags_reg[FLAG_PARK] ? MSG_PARK : MSG_OVL;
        end
        else
        begin
            msg_sel = MSG_HOLD;
        end
    end

    assign phase_new = (phase_reg == 4'(ARROW_PERIOD - 1)) ? '0 : phase_reg + 4'd1;

    assign in_msg = col_reg < 4'(MSG_COLS);
    assign marquee_col = in_msg && is_marquee(msg_mode_reg);
    assign len = rom_len(msg_mode_reg);
    assign period = rom_period(msg_mode_reg);
    assign j_in_rom = j_reg < len;
    assign j_inc = {1'b0, j_reg} + 7'd1;
    assign j_step = (j_in_rom || (j_inc < period)) ? j_inc[5:0] : '0;
    assign glyph_idx = marquee_col ? 4'(j_reg - len) : col_reg;
    assign g = glyph_reg[glyph_idx];
    assign s = shown_reg[col_reg];
    assign amt = 4'(ROLL_PERIOD - 1) - sp_reg[3:0];
    assign k = 3'(ARROW_SHIFT_STEPS - 1) - phase_reg[2:0];

    always_comb
    begin
        case (msg_mode_reg)
            MSG_COPY: msg_dots = g;
            MSG_HOLD: msg_dots = s;
            MSG_ROLL:
            begin
                if (up)
                begin
                    msg_dots = {1'b0, s[7:1]} | 8'({8'h00, g} << amt);
                end
                else
                begin
                    msg_dots = {s[6:0], 1'b0} | 8'({8'h00, g} >> amt);
                end
            end
            default: msg_dots = j_in_rom ? rom_byte(msg_mode_reg, j_reg) : g;
        endcase
        case (arrow_mode_reg)
            ARW_COPY: arrow_dots = g;
            ARW_SHIFT: arrow_dots = up ? 8'(g << k) : (g >> k);
            default: arrow_dots = s;
        endcase
        col_dots = in_msg ? msg_dots : arrow_dots;
    end

    always_comb
    begin
        state_next = state_reg;
        col_next = col_reg;
        j_next = j_reg;
        sp_next = sp_reg;
        phase_next = phase_reg;
        roll_next = roll_reg;
        active_next = active_reg;
        prev_floor_next = prev_floor_reg;
        flags_next = flags_reg;
        msg_mode_next = msg_mode_reg;
        arrow_mode_next = arrow_mode_reg;
        glyph_next = glyph_reg;
        shown_next = shown_reg;
        out_valid_next = out_valid_reg;
        out_col_next = out_col_reg;
        out_dots_next = out_dots_reg;
        out_last_next = out_last_reg;
        sp_new = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (take)
        begin
            unique case (cmd.kind)
                CMD_LOAD:
                begin
                    glyph_next[cmd.index] = cmd.data;
                end
                CMD_STATUS:
                begin
                    flags_next = cmd.flags;
                    if (cmd.floor != prev_floor_reg)
                    begin
                        roll_next = 1'b1;
                        prev_floor_next = cmd.floor;
                        sp_next = '0;
                    end
                end
                CMD_TICK:
                begin
                    state_next = ST_EMIT;
                    col_next = '0;
                    if (is_marquee(msg_sel))
                    begin
                        sp_new = 6'(wrap_mod(sp_inc, rom_period(msg_sel)));
                        sp_next = sp_new;
                        j_next = sp_new;
                        active_next = 1'b1;
                        msg_mode_next = msg_sel;
                    end
                    else if (active_reg || (roll_reg && !motion))
                    begin
                        msg_mode_next = MSG_COPY;
                        sp_next = '0;
                        roll_next = 1'b0;
                        active_next = 1'b0;
                    end
                    else if (roll_reg)
                    begin
                        sp_new = 6'(wrap_mod(sp_inc, 7'(ROLL_PERIOD)));
                        sp_next = sp_new;
                        msg_mode_next = MSG_ROLL;
                        if (sp_new == 6'(ROLL_PERIOD - 1))
                        begin
                            roll_next = 1'b0;
                        end
                    end
                    else
                    begin
                        msg_mode_next = MSG_HOLD;
                    end
                    if (motion)
                    begin
                        phase_next = phase_new;
                        arrow_mode_next = (phase_new < 4'(ARROW_SHIFT_STEPS)) ?
                                          ARW_SHIFT : ARW_HOLD;
                    end
                    else
                    begin
                        phase_next = '0;
                        arrow_mode_next = ARW_COPY;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (advance)
        begin
            shown_next[col_reg] = col_dots;
            out_valid_next = 1'b1;
            out_col_next = col_reg;
            out_dots_next = col_dots;
            out_last_next = col_reg == 4'(NUM_COLS - 1);
            col_next = col_reg + 4'd1;
            j_next = j_step;
            if (col_reg == 4'(NUM_COLS - 1))
            begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg <= '0;
            j_reg <= '0;
            sp_reg <= '0;
            phase_reg <= '0;
            roll_reg <= 1'b0;
            active_reg <= 1'b0;
            prev_floor_reg <= '0;
            flags_reg <= 10'(1 << FLAG_AUTO);
            msg_mode_reg <= MSG_HOLD;
            arrow_mode_reg <= ARW_HOLD;
            glyph_reg <= '{default: '0};
            shown_reg <= '{default: '0};
            out_valid_reg <= 1'b0;
            out_col_reg <= '0;
            out_dots_reg <= '0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg <= col_next;
            j_reg <= j_next;
            sp_reg <= sp_next;
            phase_reg <= phase_next;
            roll_reg <= roll_next;
            active_reg <= active_next;
            prev_floor_reg <= prev_floor_next;
            flags_reg <= flags_next;
            msg_mode_reg <= msg_mode_next;
            arrow_mode_reg <= arrow_mode_next;
            glyph_reg <= glyph_next;
            shown_reg <= shown_next;
            out_valid_reg <= out_valid_next;
            out_col_reg <= out_col_next;
            out_dots_reg <= out_dots_next;
            out_last_reg <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_column = out_col_reg;
    assign out_dots = out_dots_reg;
    assign last_column = out_last_reg;

    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_last_reg == (out_col_reg == 4'(NUM_COLS - 1))))
        else $error("end-of-frame mark does not match the column index");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= 4'(ARROW_PERIOD - 1))
        else $error("arrow phase left its cycle");

    a_roll_position: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && (msg_mode_reg == MSG_ROLL)
        |-> sp_reg <= 6'(ROLL_PERIOD - 1))
        else $error("roll position out of range during a frame");

endmodule

FILE: src/led_matrix_message_scroller.sv
// Driver for a 16-column by 8-row dot display with scrolling messages.
// Input channel (in_valid/in_ready) takes one beat per request: a glyph
// column load, a status update with floor code and flags, or an animation
// tick. Request code 3 is accepted and dropped.
// Each tick yields 16 output beats (out_valid/out_ready), columns 0 to 15 in
// order, with last_column set on column 15.
// Requests pass through a two-entry command queue into the column engine.
// Loads and status updates are taken only while the engine is idle. A tick
// starts a frame in which the engine computes the columns in order and
// takes no further command until column 15 has been registered.
// The engine computes one column per cycle into the output register while
// the receiver takes them; a stalled receiver holds the engine while the
// queue keeps taking requests until it is full.
// Reset clears the glyph and shown columns, scroll position, arrow phase and
// floor, and leaves the auto flag set, so ticks before the first status
// update show the plain display with no marquee.
module led_matrix_message_scroller (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  logic [3:0] column_index,
    input  logic [7:0] column_data,
    input  logic [7:0] floor_number,
    input  logic [9:0] status_flags,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] out_column,
    output logic [7:0] out_dots,
    output logic       last_column
);
    import lmms_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    lmms_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .column_index (column_index),
        .column_data  (column_data),
        .floor_number (floor_number),
        .status_flags (status_flags),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd)
    );

    lmms_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_column  (out_column),
        .out_dots    (out_dots),
        .last_column (last_column)
    );

endmodule
